### src/physical_frame_free_list_allocator_defines.svh
// Assertion macros shared by the frame allocator RTL.
`ifndef PHYSICAL_FRAME_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PHYSICAL_FRAME_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pfa_pkg.sv
// Shared types and constants of the physical frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;

    localparam int CMD_W    = 3;
    localparam int FN_W     = 12;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 13;
    localparam int KFC_W    = 13;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC_FRAME  = 3'd0,
        CMD_FREE_FRAME   = 3'd1,
        CMD_ALLOC_TABLE  = 3'd2,
        CMD_FREE_TABLE   = 3'd3,
        CMD_ENTRY_CHANGE = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_NO_FREE   = 3'd1,
        STS_KERNEL    = 3'd2,
        STS_NOT_EMPTY = 3'd3,
        STS_RANGE     = 3'd4
    } t_status;

    // Clearing sequencer state seen by the datapath.
    typedef struct packed {
        logic active;
        logic clr_count;
    } t_sweep;

    // Store write requests from the execute logic.
    typedef struct packed {
        logic link_we;
        logic cnt_we;
    } t_wr_ctl;

endpackage
`default_nettype wire

### src/pfa_in_if.sv
// Command channel interface of the frame allocator.
`timescale 1ns / 1ps
`default_nettype none
interface pfa_in_if;
    logic                       valid;
    logic                       ready;
    logic [pfa_pkg::CMD_W-1:0]  command;
    logic [pfa_pkg::FN_W-1:0]   frame_number;
    logic                       old_present;
    logic                       new_present;

    modport source (output valid, command, frame_number, old_present, new_present,
                    input ready);
    modport sink   (input valid, command, frame_number, old_present, new_present,
                    output ready);
endinterface
`default_nettype wire

### src/pfa_out_if.sv
// Result channel interface of the frame allocator.
`timescale 1ns / 1ps
`default_nettype none
interface pfa_out_if;
    logic                         valid;
    logic                         ready;
    logic [pfa_pkg::STATUS_W-1:0] status;
    logic [pfa_pkg::FN_W-1:0]     allocated_frame;
    logic [pfa_pkg::FREE_W-1:0]   frames_free;

    modport source (output valid, status, allocated_frame, frames_free, input ready);
    modport sink   (input valid, status, allocated_frame, frames_free, output ready);
endinterface
`default_nettype wire

### src/physical_frame_free_list_allocator.sv
// Top level of the physical frame allocator: a LIFO free list with per-table entry counts.
// A command waits in the execute stage and retires into the result register once that register is free
// or being drained. Entry-present changes and unused commands sustain one transfer per cycle while results
// are drained; a list command holds off the next command until it retires, set by the registered read of
// the head's link entry. Reset and every kernel_frame_count write start a clearing pass over all FRAMES
// frames (4096 by default) during which no command transfer is accepted; reset also zeroes all counts.
`timescale 1ns / 1ps
`default_nettype none
`include "physical_frame_free_list_allocator_defines.svh"
module physical_frame_free_list_allocator #(
    parameter int FRAMES            = 4096,
    parameter int ENTRIES_PER_TABLE = 512
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [pfa_pkg::KFC_W-1:0]   i_cfg_wr_data,
    pfa_in_if.sink                           i_req,
    pfa_out_if.source                        o_rsp
);
    import pfa_pkg::*;

    localparam int AW   = $clog2(FRAMES);
    localparam int LW   = AW + 1;
    localparam int CNTW = $clog2(ENTRIES_PER_TABLE + 1);
    localparam int CW   = (LW > KFC_W) ? LW : KFC_W;

    // Architectural list state.
    logic [LW-1:0]       r_kernel;
    logic [LW-1:0]       r_head;
    logic [LW-1:0]       r_free;

    // Execute stage: the accepted command waits here with its store read data.
    logic                r_ex_valid;
    logic [CMD_W-1:0]    r_ex_cmd;
    logic [FN_W-1:0]     r_ex_fn;
    logic                r_ex_oldp;
    logic                r_ex_newp;

    // Count write made at the edge that accepted the command in the execute stage.
    // The count store read missed it, so it is forwarded.
    logic                r_fwd_en;
    logic [AW-1:0]       r_fwd_addr;
    logic [CNTW-1:0]     r_fwd_data;

    // Result register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [FN_W-1:0]     r_out_frame;
    logic [FREE_W-1:0]   r_out_free;

    t_sweep              w_sweep;
    logic [AW-1:0]       w_sweep_idx;
    logic                w_in_accept;
    logic                w_advance;
    logic                w_ex_list_cmd;
    logic                w_in_list_cmd;
    logic [LW-1:0]       w_cfg_kernel;
    logic [LW-1:0]       w_link_rd;
    logic [CNTW-1:0]     w_cnt_rd;
    logic [CNTW-1:0]     w_count;

    t_status             n_status;
    logic [FN_W-1:0]     n_frame;
    logic [LW-1:0]       n_head;
    logic [LW-1:0]       n_free;
    t_wr_ctl             w_ctl;
    logic [AW-1:0]       w_link_addr;
    logic [LW-1:0]       w_link_data;
    logic [AW-1:0]       w_cnt_addr;
    logic [CNTW-1:0]     w_cnt_data;

    logic                w_link_we;
    logic [AW-1:0]       w_link_wa;
    logic [LW-1:0]       w_link_wd;
    logic                w_cnt_we;
    logic [AW-1:0]       w_cnt_wa;
    logic [CNTW-1:0]     w_cnt_wd;

    // The execute stage retires when the result register is free or being drained.
    assign w_advance     = r_ex_valid && (!r_out_valid || o_rsp.ready);
    assign w_ex_list_cmd = r_ex_cmd <= CMD_FREE_TABLE;
    assign w_in_list_cmd = i_req.command <= CMD_FREE_TABLE;

    // A list command can move the head, and the next command's link read is issued
    // from the head at its own transfer, so a command never follows a list command
    // in the very next cycle. Count updates are covered by forwarding instead.
    assign i_req.ready = !w_sweep.active
                       && (!r_ex_valid || (w_advance && !w_ex_list_cmd));
    assign w_in_accept = i_req.valid && i_req.ready;

    // Register values beyond the frame count behave as the frame count.
    assign w_cfg_kernel = (CW'(i_cfg_wr_data) > CW'(FRAMES)) ? LW'(FRAMES)
                                                             : LW'(i_cfg_wr_data);

    pfa_sweep #(
        .FRAMES (FRAMES)
    ) u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_wr_en),
        .o_sweep (w_sweep),
        .o_idx   (w_sweep_idx)
    );

    // The clearing pass owns both write ports while it runs; a command retiring then has its store writes dropped.
    always_comb begin
        if (w_sweep.active) begin
            w_link_we = 1'b1;
            w_link_wa = w_sweep_idx;
            w_link_wd = LW'(w_sweep_idx) + LW'(1);
            w_cnt_we  = w_sweep.clr_count;
            w_cnt_wa  = w_sweep_idx;
            w_cnt_wd  = '0;
        end else begin
            w_link_we = w_advance && w_ctl.link_we;
            w_link_wa = w_link_addr;
            w_link_wd = w_link_data;
            w_cnt_we  = w_advance && w_ctl.cnt_we;
            w_cnt_wa  = w_cnt_addr;
            w_cnt_wd  = w_cnt_data;
        end
    end

    pfa_ram #(
        .DEPTH (FRAMES),
        .WIDTH (LW)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_link_we),
        .i_wr_addr (w_link_wa),
        .i_wr_data (w_link_wd),
        .i_rd_en   (w_in_accept),
        .i_rd_addr (r_head[AW-1:0]),
        .o_rd_data (w_link_rd)
    );

    pfa_ram #(
        .DEPTH (FRAMES),
        .WIDTH (CNTW)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_cnt_we),
        .i_wr_addr (w_cnt_wa),
        .i_wr_data (w_cnt_wd),
        .i_rd_en   (w_in_accept),
        .i_rd_addr (AW'(i_req.frame_number)),
        .o_rd_data (w_cnt_rd)
    );

    assign w_count = (r_fwd_en && (r_fwd_addr == AW'(r_ex_fn))) ? r_fwd_data : w_cnt_rd;

    pfa_exec #(
        .FRAMES            (FRAMES),
        .ENTRIES_PER_TABLE (ENTRIES_PER_TABLE)
    ) u_exec (
        .i_cmd       (r_ex_cmd),
        .i_fn        (r_ex_fn),
        .i_oldp      (r_ex_oldp),
        .i_newp      (r_ex_newp),
        .i_head      (r_head),
        .i_free      (r_free),
        .i_kernel    (r_kernel),
        .i_link      (w_link_rd),
        .i_count     (w_count),
        .o_status    (n_status),
        .o_frame     (n_frame),
        .o_head_next (n_head),
        .o_free_next (n_free),
        .o_ctl       (w_ctl),
        .o_link_addr (w_link_addr),
        .o_link_data (w_link_data),
        .o_cnt_addr  (w_cnt_addr),
        .o_cnt_data  (w_cnt_data)
    );

    // Control state. A kernel_frame_count write reloads the head and free count at once;
    // the links follow through the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel    <= '0;
            r_head      <= '0;
            r_free      <= LW'(FRAMES);
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_en    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_kernel <= w_cfg_kernel;
                r_head   <= w_cfg_kernel;
                r_free   <= LW'(FRAMES) - w_cfg_kernel;
            end else if (w_advance) begin
                r_head <= n_head;
                r_free <= n_free;
            end

            if (w_in_accept) begin
                r_ex_valid <= 1'b1;
            end else if (w_advance) begin
                r_ex_valid <= 1'b0;
            end

            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_in_accept) begin
                r_fwd_en <= w_advance && w_ctl.cnt_we;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_ex_cmd   <= i_req.command;
            r_ex_fn    <= i_req.frame_number;
            r_ex_oldp  <= i_req.old_present;
            r_ex_newp  <= i_req.new_present;
            r_fwd_addr <= w_cnt_addr;
            r_fwd_data <= w_cnt_data;
        end
        if (w_advance) begin
            r_out_status <= n_status;
            r_out_frame  <= n_frame;
            r_out_free   <= FREE_W'(n_free);
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.allocated_frame = r_out_frame;
    assign o_rsp.frames_free     = r_out_free;

    `PFA_ASSERT_NEXT(a_list_cmd_gap, i_clk, i_rst_n, w_in_accept && w_in_list_cmd, !i_req.ready, "command accepted right after a list command")
    `PFA_ASSERT_NEXT(a_retire_shows_result, i_clk, i_rst_n, w_advance, o_rsp.valid, "retired command produced no result")
    `PFA_ASSERT_NEXT(a_cfg_starts_clear, i_clk, i_rst_n, i_cfg_wr_en, w_sweep.active && !i_req.ready, "register write did not start the clearing pass")
    `PFA_ASSERT_NOW(a_list_bounded, i_clk, i_rst_n, !w_sweep.active, (r_free <= LW'(FRAMES)) && (r_kernel <= LW'(FRAMES)), "free count or kernel region exceeds the frame count")
endmodule
`default_nettype wire

### src/pfa_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pfa_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 13
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read returns the contents from before a write to the same address.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

### src/pfa_sweep.sv
// Clearing sequencer that rewrites the link store and, after reset, the count store.
`timescale 1ns / 1ps
`default_nettype none
module pfa_sweep #(
    parameter int FRAMES = 4096
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output pfa_pkg::t_sweep                o_sweep,
    output logic      [$clog2(FRAMES)-1:0] o_idx
);
    import pfa_pkg::*;

    localparam int AW = $clog2(FRAMES);

    logic          r_active;
    logic          r_clr;
    logic [AW-1:0] r_idx;

    // A restart keeps a pending count clear so that reset always wipes the counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_clr    <= 1'b1;
            r_idx    <= '0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_idx    <= '0;
        end else if (r_active) begin
            if (r_idx == AW'(FRAMES - 1)) begin
                r_active <= 1'b0;
                r_clr    <= 1'b0;
            end else begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    assign o_sweep.active    = r_active;
    assign o_sweep.clr_count = r_clr;
    assign o_idx             = r_idx;
endmodule
`default_nettype wire

### src/pfa_exec.sv
// Execute logic: decides one command from the registered operands.
`timescale 1ns / 1ps
`default_nettype none
module pfa_exec #(
    parameter int FRAMES            = 4096,
    parameter int ENTRIES_PER_TABLE = 512
) (
    input  wire logic [pfa_pkg::CMD_W-1:0]                  i_cmd,
    input  wire logic [pfa_pkg::FN_W-1:0]                   i_fn,
    input  wire logic                                       i_oldp,
    input  wire logic                                       i_newp,
    input  wire logic [$clog2(FRAMES):0]                    i_head,
    input  wire logic [$clog2(FRAMES):0]                    i_free,
    input  wire logic [$clog2(FRAMES):0]                    i_kernel,
    input  wire logic [$clog2(FRAMES):0]                    i_link,
    input  wire logic [$clog2(ENTRIES_PER_TABLE+1)-1:0]     i_count,
    output pfa_pkg::t_status                                o_status,
    output logic      [pfa_pkg::FN_W-1:0]                   o_frame,
    output logic      [$clog2(FRAMES):0]                    o_head_next,
    output logic      [$clog2(FRAMES):0]                    o_free_next,
    output pfa_pkg::t_wr_ctl                                o_ctl,
    output logic      [$clog2(FRAMES)-1:0]                  o_link_addr,
    output logic      [$clog2(FRAMES):0]                    o_link_data,
    output logic      [$clog2(FRAMES)-1:0]                  o_cnt_addr,
    output logic      [$clog2(ENTRIES_PER_TABLE+1)-1:0]     o_cnt_data
);
    import pfa_pkg::*;

    localparam int AW   = $clog2(FRAMES);
    localparam int LW   = AW + 1;
    localparam int CNTW = $clog2(ENTRIES_PER_TABLE + 1);
    localparam int CW   = (LW > KFC_W) ? LW : KFC_W;

    logic          w_head_ok;
    logic          w_fn_range;
    logic          w_fn_kernel;
    logic [LW-1:0] w_free_dec;
    logic [LW-1:0] w_free_inc;
    logic          w_push;

    assign w_head_ok   = i_head < LW'(FRAMES);
    assign w_fn_range  = CW'(i_fn) >= CW'(FRAMES);
    assign w_fn_kernel = CW'(i_fn) < CW'(i_kernel);
    assign w_free_dec  = (i_free != '0) ? i_free - LW'(1) : i_free;
    assign w_free_inc  = (i_free < LW'(FRAMES)) ? i_free + LW'(1) : i_free;

    always_comb begin
        o_status    = STS_OK;
        o_frame     = '0;
        o_head_next = i_head;
        o_free_next = i_free;
        o_ctl       = '0;
        o_link_addr = i_head[AW-1:0];
        o_link_data = '0;
        o_cnt_addr  = AW'(i_fn);
        o_cnt_data  = i_count;
        w_push      = 1'b0;

        case (t_cmd'(i_cmd))
            CMD_ALLOC_FRAME, CMD_ALLOC_TABLE: begin
                if (!w_head_ok) begin
                    o_status = STS_NO_FREE;
                end else begin
                    // Pop the head; its link is cleared.
                    o_frame       = FN_W'(i_head);
                    o_head_next   = i_link;
                    o_free_next   = w_free_dec;
                    o_ctl.link_we = 1'b1;
                    if (t_cmd'(i_cmd) == CMD_ALLOC_TABLE) begin
                        o_ctl.cnt_we = 1'b1;
                        o_cnt_addr   = i_head[AW-1:0];
                        o_cnt_data   = '0;
                    end
                end
            end
            CMD_FREE_FRAME: begin
                if (w_fn_kernel) begin
                    o_status = STS_KERNEL;
                end else if (w_fn_range) begin
                    o_status = STS_RANGE;
                end else begin
                    w_push = 1'b1;
                end
            end
            CMD_FREE_TABLE: begin
                if (w_fn_range) begin
                    o_status = STS_RANGE;
                end else if (i_count != '0) begin
                    o_status = STS_NOT_EMPTY;
                end else if (w_fn_kernel) begin
                    o_status = STS_KERNEL;
                end else begin
                    w_push = 1'b1;
                end
            end
            CMD_ENTRY_CHANGE: begin
                if (w_fn_range) begin
                    o_status = STS_RANGE;
                end else if (i_newp && !i_oldp) begin
                    o_ctl.cnt_we = 1'b1;
                    if (i_count < CNTW'(ENTRIES_PER_TABLE)) begin
                        o_cnt_data = i_count + CNTW'(1);
                    end
                end else if (!i_newp && i_oldp) begin
                    o_ctl.cnt_we = 1'b1;
                    if (i_count != '0) begin
                        o_cnt_data = i_count - CNTW'(1);
                    end
                end
            end
            default: begin
                o_status = STS_RANGE;
            end
        endcase

        // A push links the frame in front of the current head.
        if (w_push) begin
            o_ctl.link_we = 1'b1;
            o_link_addr   = AW'(i_fn);
            o_link_data   = i_head;
            o_head_next   = LW'(i_fn);
            o_free_next   = w_free_inc;
        end
    end
endmodule
`default_nettype wire
